/* src/topological_sort_kahn_unit_defines.svh */
// Assertion macros used by the port checker file.
`ifndef TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tsk_pkg.sv */
// Types and codes shared by the topological sort unit.
package tsk_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_RUN    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    logic load_label;
    logic clear_edges;
    logic latch_ins;
    logic start_run;
    logic cnt_clr;
    logic find_rd;
    logic find_cmp;
    logic ins_rd;
    logic ins_wr;
    logic deg_rd;
    logic deg_acc;
    logic seed_pend;
    logic push_step;
    logic pop;
    logic v_rd;
    logic upd;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic pend_bit;
    logic found_both;
    logic q_empty;
    logic none_emitted;
    logic out_free;
  } sts_t;

endpackage

/* src/tsk_ctrl.sv */
// Sequencer for load, insert, clear and the Kahn sort run.
module tsk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  input  tsk_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output tsk_pkg::cmd_t cmd_o
);
  import tsk_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_FIND_RD  = 14'b00000000000010,
    ST_FIND_CMP = 14'b00000000000100,
    ST_INS_RD   = 14'b00000000001000,
    ST_INS_WR   = 14'b00000000010000,
    ST_DEG_RD   = 14'b00000000100000,
    ST_DEG_ACC  = 14'b00000001000000,
    ST_SEED     = 14'b00000010000000,
    ST_POP      = 14'b00000100000000,
    ST_VRD      = 14'b00001000000000,
    ST_UPD      = 14'b00010000000000,
    ST_PUSH     = 14'b00100000000000,
    ST_EMIT     = 14'b01000000000000,
    ST_EMPTY    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(action_i))
            ACT_LOAD:  cmd_o.load_label = 1'b1;
            ACT_CLEAR: cmd_o.clear_edges = 1'b1;
            ACT_INSERT: begin
              cmd_o.latch_ins = 1'b1;
              cmd_o.cnt_clr   = 1'b1;
              state_d         = ST_FIND_RD;
            end
            ACT_RUN: begin
              cmd_o.start_run = 1'b1;
              cmd_o.cnt_clr   = 1'b1;
              state_d         = ST_DEG_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND_RD: begin
        if (sts_i.cnt_done) begin
          state_d = sts_i.found_both ? ST_INS_RD : ST_IDLE;
        end else begin
          cmd_o.find_rd = 1'b1;
          state_d       = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        cmd_o.find_cmp = 1'b1;
        state_d        = ST_FIND_RD;
      end
      ST_INS_RD: begin
        cmd_o.ins_rd = 1'b1;
        state_d      = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DEG_RD: begin
        if (sts_i.cnt_done) begin
          cmd_o.seed_pend = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = ST_SEED;
        end else begin
          cmd_o.deg_rd = 1'b1;
          state_d      = ST_DEG_ACC;
        end
      end
      ST_DEG_ACC: begin
        cmd_o.deg_acc = 1'b1;
        state_d       = ST_DEG_RD;
      end
      ST_SEED: begin
        if (sts_i.cnt_done) state_d = ST_POP;
        else cmd_o.push_step = 1'b1;
      end
      ST_POP: begin
        if (sts_i.q_empty) begin
          state_d = sts_i.none_emitted ? ST_EMPTY : ST_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_VRD;
        end
      end
      ST_VRD: begin
        cmd_o.v_rd = 1'b1;
        state_d    = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd     = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.cnt_done) state_d = ST_EMIT;
        else cmd_o.push_step = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_POP;
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

/* src/tsk_datapath.sv */
// Label, edge and queue memories, in-degree lanes, counters and result register.
module tsk_datapath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned LABEL_WIDTH  = 16,
  localparam int unsigned IW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsk_pkg::cmd_t          cmd_i,
  output tsk_pkg::sts_t          sts_o,
  input  logic                   cfg_we_i,
  input  logic [CW-1:0]          cfg_vertex_count_i,
  input  logic [IW-1:0]          vertex_index_i,
  input  logic [LABEL_WIDTH-1:0] vertex_label_i,
  input  logic [LABEL_WIDTH-1:0] src_label_i,
  input  logic [LABEL_WIDTH-1:0] dst_label_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [LABEL_WIDTH-1:0] out_label_o,
  output logic                   out_is_last_o,
  output logic                   out_cycle_found_o,
  output logic                   out_no_vertex_o
);
  import tsk_pkg::*;

  localparam int unsigned RstCount = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  logic [CW-1:0] n_q, cnt_q, head_q, tail_q, emitted_q;
  logic [IW-1:0] cnt_idx;

  logic [LABEL_WIDTH-1:0]  label_mem [MAX_VERTICES];
  logic [LABEL_WIDTH-1:0]  label_rd_q;
  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_rd_q;
  logic                    row_rd_vld_q;
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [IW-1:0]           q_mem [MAX_VERTICES];
  logic [IW-1:0]           q_rd_q;

  logic [CW-1:0]           deg_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pend_q;

  logic [LABEL_WIDTH-1:0] src_q, dst_q;
  logic [IW-1:0]          a_q, b_q, v_q;
  logic                   fa_q, fb_q;

  logic                   out_valid_q, out_last_q, out_cyc_q, out_none_q;
  logic [LABEL_WIDTH-1:0] out_label_q;

  logic [MAX_VERTICES-1:0] in_use, zero_vec, live, newly, row_eff, row_wb, row_set;
  logic [CW-1:0]           dec_deg [MAX_VERTICES];
  logic [IW-1:0]           row_raddr, row_waddr;
  logic [MAX_VERTICES-1:0] row_wdata;
  logic                    row_we, out_free, q_empty;
  logic [CW:0]             emitted_next;

  assign cnt_idx  = cnt_q[IW-1:0];
  assign row_eff  = row_rd_vld_q ? row_rd_q : '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_empty  = (head_q == tail_q);
  assign emitted_next = {1'b0, emitted_q} + {{CW{1'b0}}, 1'b1};

  // per-vertex lanes
  always_comb begin
    row_set = '0;
    row_set[b_q] = 1'b1;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      in_use[j]   = (CW'(j) < n_q);
      zero_vec[j] = in_use[j] && (deg_q[j] == '0);
      live[j]     = in_use[j] && (deg_q[j] != '0);
      dec_deg[j]  = deg_q[j] - {{(CW-1){1'b0}}, row_eff[j]};
      newly[j]    = live[j] && row_eff[j] && (deg_q[j] == {{(CW-1){1'b0}}, 1'b1});
      row_wb[j]   = row_eff[j] && !live[j];
    end
  end

  always_comb begin
    row_raddr = q_rd_q;
    if (cmd_i.deg_rd) row_raddr = cnt_idx;
    else if (cmd_i.ins_rd) row_raddr = a_q;
    row_we    = cmd_i.ins_wr || cmd_i.upd;
    row_waddr = cmd_i.ins_wr ? a_q : v_q;
    row_wdata = cmd_i.ins_wr ? (row_eff | row_set) : row_wb;
  end

  assign sts_o.cnt_done     = (cnt_q == n_q);
  assign sts_o.pend_bit     = pend_q[cnt_idx];
  assign sts_o.found_both   = fa_q && fb_q;
  assign sts_o.q_empty      = q_empty;
  assign sts_o.none_emitted = (emitted_q == '0);
  assign sts_o.out_free     = out_free;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_label && (32'(vertex_index_i) < MAX_VERTICES)) begin
      label_mem[vertex_index_i] <= vertex_label_i;
    end
    if (cmd_i.find_rd) label_rd_q <= label_mem[cnt_idx];
    else if (cmd_i.v_rd) label_rd_q <= label_mem[q_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (cmd_i.deg_rd || cmd_i.ins_rd || cmd_i.v_rd) begin
      row_rd_q     <= row_mem[row_raddr];
      row_rd_vld_q <= row_vld_q[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_step && pend_q[cnt_idx]) q_mem[tail_q[IW-1:0]] <= cnt_idx;
    if (cmd_i.pop) q_rd_q <= q_mem[head_q[IW-1:0]];
  end

  // in-degree lanes, pending vector and working registers
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (cmd_i.start_run) deg_q[j] <= '0;
      else if (cmd_i.deg_acc) deg_q[j] <= deg_q[j] + {{(CW-1){1'b0}}, row_eff[j] & in_use[j]};
      else if (cmd_i.upd && live[j]) deg_q[j] <= dec_deg[j];
    end
    if (cmd_i.seed_pend) pend_q <= zero_vec;
    else if (cmd_i.upd) pend_q <= newly;
    if (cmd_i.latch_ins) begin
      src_q <= src_label_i;
      dst_q <= dst_label_i;
    end
    if (cmd_i.v_rd) v_q <= q_rd_q;
    if (cmd_i.find_cmp && !fa_q && (label_rd_q == src_q)) a_q <= cnt_idx;
    if (cmd_i.find_cmp && !fb_q && (label_rd_q == dst_q)) b_q <= cnt_idx;
    if (cmd_i.emit) begin
      out_label_q <= label_rd_q;
      out_last_q  <= q_empty;
      out_cyc_q   <= q_empty && (emitted_next < {1'b0, n_q});
      out_none_q  <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      out_label_q <= '0;
      out_last_q  <= 1'b1;
      out_cyc_q   <= (n_q != '0);
      out_none_q  <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CW'(RstCount);
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      emitted_q   <= '0;
      row_vld_q   <= '0;
      fa_q        <= 1'b0;
      fb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= (cfg_vertex_count_i > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                         : cfg_vertex_count_i;
      end
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.find_cmp || cmd_i.deg_acc || cmd_i.push_step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.start_run) begin
        head_q    <= '0;
        tail_q    <= '0;
        emitted_q <= '0;
      end else begin
        if (cmd_i.pop) head_q <= head_q + 1'b1;
        if (cmd_i.push_step && pend_q[cnt_idx]) tail_q <= tail_q + 1'b1;
        if (cmd_i.emit) emitted_q <= emitted_next[CW-1:0];
      end
      if (cmd_i.clear_edges) row_vld_q <= '0;
      else if (row_we) row_vld_q[row_waddr] <= 1'b1;
      if (cmd_i.latch_ins) begin
        fa_q <= 1'b0;
        fb_q <= 1'b0;
      end else if (cmd_i.find_cmp) begin
        if (label_rd_q == src_q) fa_q <= 1'b1;
        if (label_rd_q == dst_q) fb_q <= 1'b1;
      end
      if (cmd_i.emit || cmd_i.emit_empty) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_label_o       = out_label_q;
  assign out_is_last_o     = out_last_q;
  assign out_cycle_found_o = out_cyc_q;
  assign out_no_vertex_o   = out_none_q;

endmodule

/* src/topological_sort_kahn_unit.sv */
// Load and clear complete from idle; insert scans the labels, then reads and writes a row.
// A run accumulates in-degrees row by row and seeds the queue, then for each emitted
// vertex pops the queue, reads label and row, updates the lanes and scans to enqueue in order.
// One transaction at a time; the result register lets the sorter work on up to its next emit.
// Reset: controller idle, vertex_count 64 (capped at MAX_VERTICES), all edge rows read as
// empty through per-row valid bits; labels are undefined until loaded.
module topological_sort_kahn_unit #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned LABEL_WIDTH  = 16,
  localparam int unsigned IW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CW-1:0]          cfg_vertex_count_i,
  // input transactions
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [IW-1:0]          vertex_index_i,
  input  logic [LABEL_WIDTH-1:0] vertex_label_i,
  input  logic [LABEL_WIDTH-1:0] src_label_i,
  input  logic [LABEL_WIDTH-1:0] dst_label_i,
  // result transactions
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LABEL_WIDTH-1:0] out_label_o,
  output logic                   out_is_last_o,
  output logic                   out_cycle_found_o,
  output logic                   out_no_vertex_o
);
  import tsk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller walks the phases: label search, edge set, in-degree accumulate,
  // seeding, and the pop / update / enqueue / emit loop.
  tsk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Datapath: reads one row of the edge matrix at a time, all in-degree lanes in parallel.
  tsk_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_WIDTH  (LABEL_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .vertex_index_i     (vertex_index_i),
    .vertex_label_i     (vertex_label_i),
    .src_label_i        (src_label_i),
    .dst_label_i        (dst_label_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_label_o        (out_label_o),
    .out_is_last_o      (out_is_last_o),
    .out_cycle_found_o  (out_cycle_found_o),
    .out_no_vertex_o    (out_no_vertex_o)
  );

endmodule

/* src/tsk_checker.sv */
// Port-level checks for the topological sort unit, bound to the top level.
`include "topological_sort_kahn_unit_defines.svh"

module tsk_port_checker #(
  parameter int unsigned LABEL_WIDTH = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [1:0]             action_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [LABEL_WIDTH-1:0] out_label_o,
  input logic                   out_is_last_o,
  input logic                   out_cycle_found_o,
  input logic                   out_no_vertex_o
);
  import tsk_pkg::*;

  `TSK_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_label_o), "stalled result changed")
  `TSK_ASSERT_NXT(a_busy_after_run, in_valid_i && !in_stall_o && (action_i == ACT_RUN),
                  in_stall_o, "run accepted but unit not busy")
  `TSK_ASSERT_IMP(a_flags_on_last, out_valid_o && (out_no_vertex_o || out_cycle_found_o),
                  out_is_last_o, "empty or cycle flag on non-final result")
  `TSK_ASSERT_IMP(a_result_while_busy, $rose(out_valid_o), $past(in_stall_o),
                  "result appeared while idle")

endmodule

bind topological_sort_kahn_unit tsk_port_checker #(.LABEL_WIDTH(LABEL_WIDTH)) u_tsk_checker (.*);

/* tb/sv/tsk_checker.sv */
// Transaction checker for the topological sort unit: predicts and compares results.
module tsk_checker
  import tsk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_vertex_count_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  vertex_index_i,
  input  logic [15:0] vertex_label_i,
  input  logic [15:0] src_label_i,
  input  logic [15:0] dst_label_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [15:0] out_label_o,
  input  logic        out_is_last_o,
  input  logic        out_cycle_found_o,
  input  logic        out_no_vertex_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] label;
    logic        last;
    logic        cyc;
    logic        none;
  } sort_res_t;

  logic [6:0]  count_q;
  logic [15:0] labels_q [64];
  logic [63:0] edges_q [64];
  sort_res_t   order_q [$];

  assign pending_o = order_q.size();

  function automatic int first_slot(logic [15:0] lab, int n);
    for (int i = 0; i < n; i++) if (labels_q[i] == lab) return i;
    return n;
  endfunction

  // Kahn order over slots 0..n-1; consumed edges are cleared
  task automatic sort_graph();
    int n, head, emitted;
    int deg [64];
    int fifo [$];
    int v;
    sort_res_t r;
    n = (count_q > 64) ? 64 : count_q;
    emitted = 0;
    for (int j = 0; j < n; j++) begin
      deg[j] = 0;
      for (int i = 0; i < n; i++) deg[j] += edges_q[i][j];
      if (deg[j] == 0) fifo.push_back(j);
    end
    head = 0;
    while (head < fifo.size()) begin
      v = fifo[head];
      head++;
      r = '{label: labels_q[v], last: 1'b0, cyc: 1'b0, none: 1'b0};
      order_q.push_back(r);
      emitted++;
      for (int j = 0; j < n; j++) begin
        if (deg[j] != 0) begin
          deg[j] -= edges_q[v][j];
          edges_q[v][j] = 1'b0;
          if (deg[j] == 0) fifo.push_back(j);
        end
      end
    end
    if (emitted == 0) begin
      r = '{label: 16'd0, last: 1'b1, cyc: (n != 0), none: 1'b1};
      order_q.push_back(r);
    end else begin
      order_q[$].last = 1'b1;
      order_q[$].cyc  = (emitted < n);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int a, b, n;
    sort_res_t exp_r;
    if (!rst_ni) begin
      count_q = 7'd64;
      fail_count_o = 0;
      for (int i = 0; i < 64; i++) edges_q[i] = '0;
      order_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (order_q.size() == 0) begin
          $error("unexpected result label %0h", out_label_o);
          fail_count_o++;
        end else begin
          exp_r = order_q.pop_front();
          if (out_label_o !== exp_r.label) begin
            $error("out_label exp %0h got %0h", exp_r.label, out_label_o);
            fail_count_o++;
          end
          if (out_is_last_o !== exp_r.last) begin
            $error("is_last exp %0b got %0b", exp_r.last, out_is_last_o);
            fail_count_o++;
          end
          if (out_cycle_found_o !== exp_r.cyc) begin
            $error("cycle_found exp %0b got %0b", exp_r.cyc, out_cycle_found_o);
            fail_count_o++;
          end
          if (out_no_vertex_o !== exp_r.none) begin
            $error("no_vertex exp %0b got %0b", exp_r.none, out_no_vertex_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        n = (count_q > 64) ? 64 : count_q;
        case (action_e'(action_i))
          ACT_LOAD: labels_q[vertex_index_i] = vertex_label_i;
          ACT_INSERT: begin
            a = first_slot(src_label_i, n);
            b = first_slot(dst_label_i, n);
            if (a < n && b < n) edges_q[a][b] = 1'b1;
          end
          ACT_CLEAR: for (int i = 0; i < 64; i++) edges_q[i] = '0;
          default: sort_graph();
        endcase
      end
      if (cfg_we_i) count_q = cfg_vertex_count_i;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the topological sort unit: stimulus, stalls and verdict.
module tb_top;
  import tsk_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_vertex_count_i = 7'd64;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_LOAD;
  logic [5:0]  vertex_index_i = '0;
  logic [15:0] vertex_label_i = '0;
  logic [15:0] src_label_i = '0;
  logic [15:0] dst_label_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_label_o;
  logic        out_is_last_o, out_cycle_found_o, out_no_vertex_o;
  int          fail_count, pending;

  // Stall profile: 0 random, 1 never stall, 2 long hold-off
  int sink_mode = 0;
  int hold_left = 0;
  bit quiet_src = 1'b0;
  // Labels currently held in slots 0..count-1 (all slots loaded before use)
  logic [15:0] graph_labels [64];
  int          cur_count = 64;

  always #6 clk_i = ~clk_i;

  topological_sort_kahn_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_vertex_count_i,
    .in_valid_i, .in_stall_o, .action_i, .vertex_index_i, .vertex_label_i,
    .src_label_i, .dst_label_i,
    .out_valid_o, .out_stall_i, .out_label_o, .out_is_last_o,
    .out_cycle_found_o, .out_no_vertex_o
  );

  tsk_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_vertex_count_i,
    .in_valid_i, .in_stall_o, .action_i, .vertex_index_i, .vertex_label_i,
    .src_label_i, .dst_label_i,
    .out_valid_o, .out_stall_i, .out_label_o, .out_is_last_o,
    .out_cycle_found_o, .out_no_vertex_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result-side stall driver, updated on the falling edge
  always @(negedge clk_i) begin
    if (sink_mode == 2 && hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (sink_mode == 1) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 31);
    end
  end

  // Offer one transaction and hold it until accepted; valid drops while idling.
  task automatic send(action_e act, logic [5:0] idx, logic [15:0] lab,
                      logic [15:0] src, logic [15:0] dst);
    if (!quiet_src) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    vertex_index_i <= idx;
    vertex_label_i <= lab;
    src_label_i    <= src;
    dst_label_i    <= dst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain all results, then allow for any trailing work before a config write.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic set_count(int n);
    settle();
    cfg_we_i <= 1'b1;
    cfg_vertex_count_i <= n[6:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = n;
  endtask

  // Load all 64 slots with distinct labels (random high bits)
  task automatic load_all();
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < 64; i++) begin
      graph_labels[i] = {base[15:6] ^ 10'(i * 37), 6'(i)};
      send(ACT_LOAD, 6'(i), graph_labels[i], 16'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_label();
    if (cur_count == 0 || $urandom_range(9) == 0) return 16'($urandom);
    return graph_labels[$urandom_range(cur_count - 1)];
  endfunction

  // Random DAG-ish edge set (forward edges) with an occasional back edge or self loop
  task automatic random_graph(int edges);
    int a, b;
    for (int e = 0; e < edges; e++) begin
      a = $urandom_range(cur_count - 1);
      b = $urandom_range(cur_count - 1);
      if ($urandom_range(7) != 0 && a > b) begin
        int t;
        t = a; a = b; b = t;
      end
      if ($urandom_range(15) == 0)
        send(ACT_INSERT, 6'($urandom), 16'($urandom), 16'($urandom), graph_labels[b]);
      else
        send(ACT_INSERT, 6'($urandom), 16'($urandom), graph_labels[a], graph_labels[b]);
    end
  endtask

  initial begin
    int n;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full 64-vertex graph, empty run (all isolated), edge chain, self loop
    load_all();
    send(ACT_LOAD, 6'd63, 16'hFFFF, 16'h0, 16'hFFFF);
    graph_labels[63] = 16'hFFFF;
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[0], graph_labels[63]);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[63], graph_labels[1]);
    send(ACT_INSERT, 6'd0, 16'h0, 16'h1234 ^ graph_labels[5], graph_labels[2]);
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[3], graph_labels[3]);
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    send(ACT_CLEAR, 6'd0, 16'h0, 16'h0, 16'h0);
    set_count(0);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[0], graph_labels[1]);
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    set_count(1);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[0], graph_labels[0]);
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    // Cycle of two, plus duplicate label in slot 1 mapping to slot 0
    set_count(3);
    send(ACT_CLEAR, 6'd0, 16'h0, 16'h0, 16'h0);
    send(ACT_LOAD, 6'd1, graph_labels[0], 16'h0, 16'h0);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[0], graph_labels[2]);
    send(ACT_INSERT, 6'd0, 16'h0, graph_labels[2], graph_labels[0]);
    send(ACT_RUN, 6'd0, 16'h0, 16'h0, 16'h0);
    send(ACT_LOAD, 6'd1, graph_labels[1], 16'h0, 16'h0);

    // Pressure: long result hold-off while runs keep coming
    set_count(8);
    sink_mode = 2;
    hold_left = 2000;
    quiet_src = 1'b1;
    for (int k = 0; k < 3; k++) begin
      random_graph(4);
      send(ACT_RUN, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    quiet_src = 1'b0;
    sink_mode = 0;

    // Random phases with varying counts, mostly small
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: n = 64;
        1: n = 2;
        default: n = $urandom_range(2, 12);
      endcase
      set_count(n);
      if (ph == 4) begin
        sink_mode = 1;
        quiet_src = 1'b1;
      end
      if (ph == 5) begin
        sink_mode = 0;
        quiet_src = 1'b0;
      end
      if ($urandom_range(1))
        send(ACT_CLEAR, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_graph((n == 64) ? 6 : $urandom_range(1, n + 2));
      send(ACT_RUN, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      send(ACT_INSERT, 6'($urandom), 16'($urandom), pick_label(), pick_label());
    end
    set_count(127);
    send(ACT_RUN, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("PASS topological_sort_kahn_unit");
    else $display("FAIL topological_sort_kahn_unit");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL topological_sort_kahn_unit");
    $finish;
  end

endmodule
